### rtl/core/stps_pkg.sv
// shared types and constants of the sphere trace pixel shader
// command and status structs between controller and datapath, widths, colours
// no dependencies
package stps_pkg;

	localparam int FRAC_BITS = 16;

	// widths of the datapath registers
	localparam int MAG_W  = 48;
	localparam int POS_W  = 48;
	localparam int DIST_W = 51;
	localparam int DIV_W  = 58;
	localparam int PROD_W = 65;
	localparam int ACC_W  = 64;
	localparam int DIR_W  = FRAC_BITS + 1;
	localparam int K_W    = 5;
	localparam int CNT_W  = 5;

	// iteration counts of the bit-serial units, last count value
	localparam logic [CNT_W-1:0] RT_LAST   = CNT_W'(31);
	localparam logic [CNT_W-1:0] NORM_LAST = CNT_W'(DIR_W - 1);
	localparam logic [CNT_W-1:0] COL_LAST  = CNT_W'(7);

	// configuration register indexes
	localparam logic [2:0] CFG_EYE_X     = 3'd0;
	localparam logic [2:0] CFG_EYE_Y     = 3'd1;
	localparam logic [2:0] CFG_EYE_Z     = 3'd2;
	localparam logic [2:0] CFG_RADIUS    = 3'd3;
	localparam logic [2:0] CFG_THRESHOLD = 3'd4;
	localparam logic [2:0] CFG_GROUND    = 3'd5;

	// reset values
	localparam logic [31:0] EYE_RST    = 32'(10 << FRAC_BITS);
	localparam logic [30:0] RADIUS_RST = 31'(2 << FRAC_BITS);
	localparam logic [16:0] THR_RST    = 17'(((1 << FRAC_BITS) + 999) / 1000);
	localparam logic [30:0] GROUND_RST = 31'(40 << FRAC_BITS);

	// miss colours
	localparam logic [7:0] COL_FULL = 8'd255;
	localparam logic [7:0] COL_MID  = 8'd196;
	localparam logic [7:0] COL_LOW  = 8'd32;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_SHL,
		OP_ZERO_DIR,
		OP_MUL_GND,
		OP_GND,
		OP_MUL_SQ,
		OP_ACC,
		OP_RT_INIT,
		OP_RT_STEP,
		OP_DIV_NORM,
		OP_DIV_STEP,
		OP_DIR_SET,
		OP_DIST_LOAD,
		OP_SHR,
		OP_DIST_SET,
		OP_MUL_ADV,
		OP_ADV,
		OP_COL_LOAD,
		OP_COL_SET,
		OP_MISS,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] lane;
		logic       hit;
		logic       cap;
	} dp_cmd_t;

	typedef struct packed {
		logic mag_zero;
		logic mag_norm;
		logic mag_wide;
		logic nd_grows;
		logic nd_hit;
	} dp_sts_t;

endpackage

### rtl/core/stps_ctrl.sv
// march controller: sequences the shared datapath one operation per cycle
// depends on stps_pkg for the command and status structs
module stps_ctrl #(
	parameter int MAX_STEPS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	input  stps_pkg::dp_sts_t sts,
	output stps_pkg::dp_cmd_t cmd
);

	localparam int STEP_W = $clog2(MAX_STEPS + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_GMUL, S_GCMP, S_NSHIFT, S_SQM, S_SQA, S_RTI, S_RT,
		S_DVL, S_DV, S_DSET, S_DLD, S_DSHR, S_DFIN, S_AM, S_AA,
		S_CL, S_CD, S_CS, S_MISS, S_FIN
	} state_t;

	state_t                       state_q;
	logic [1:0]                   lane_q;
	logic [stps_pkg::CNT_W-1:0]   cnt_q;
	logic [STEP_W-1:0]            n_q;
	logic                         norm_q;
	logic                         first_q;
	logic                         hit_q;
	logic                         cap_q;
	logic                         done_q;
	logic                         grows;

	assign busy  = (state_q != S_IDLE);
	assign done  = done_q;
	assign grows = !first_q && sts.nd_grows;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lane_q  <= 2'd0;
			cnt_q   <= '0;
			n_q     <= '0;
			norm_q  <= 1'b0;
			first_q <= 1'b0;
			hit_q   <= 1'b0;
			cap_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_GMUL;
						norm_q  <= 1'b1;
						first_q <= 1'b1;
						hit_q   <= 1'b0;
						cap_q   <= 1'b0;
						n_q     <= '0;
					end
				end
				S_GMUL: state_q <= S_GCMP;
				S_GCMP: state_q <= S_NSHIFT;
				S_NSHIFT: begin
					if (sts.mag_zero) begin
						norm_q  <= 1'b0;
						state_q <= S_DLD;
					end else if (sts.mag_norm) begin
						lane_q  <= 2'd0;
						state_q <= S_SQM;
					end
				end
				S_SQM: state_q <= S_SQA;
				S_SQA: begin
					if (lane_q == 2'd2) begin
						state_q <= S_RTI;
					end else begin
						lane_q  <= lane_q + 2'd1;
						state_q <= S_SQM;
					end
				end
				S_RTI: begin
					cnt_q   <= '0;
					state_q <= S_RT;
				end
				S_RT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == stps_pkg::RT_LAST) begin
						lane_q  <= 2'd0;
						state_q <= norm_q ? S_DVL : S_DFIN;
					end
				end
				S_DVL: begin
					cnt_q   <= '0;
					state_q <= S_DV;
				end
				S_DV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == stps_pkg::NORM_LAST) begin
						state_q <= S_DSET;
					end
				end
				S_DSET: begin
					if (lane_q == 2'd2) begin
						norm_q  <= 1'b0;
						state_q <= S_DLD;
					end else begin
						lane_q  <= lane_q + 2'd1;
						state_q <= S_DVL;
					end
				end
				S_DLD: state_q <= S_DSHR;
				S_DSHR: begin
					if (!sts.mag_wide) begin
						lane_q  <= 2'd0;
						state_q <= S_SQM;
					end
				end
				S_DFIN: begin
					lane_q <= 2'd0;
					if (grows) begin
						state_q <= S_MISS;
					end else begin
						first_q <= 1'b0;
						if (sts.nd_hit) begin
							hit_q   <= 1'b1;
							state_q <= S_CL;
						end else if (n_q >= STEP_W'(MAX_STEPS)) begin
							cap_q   <= 1'b1;
							state_q <= S_MISS;
						end else begin
							state_q <= S_AM;
						end
					end
				end
				S_AM: state_q <= S_AA;
				S_AA: begin
					if (lane_q == 2'd2) begin
						n_q     <= n_q + 1'b1;
						state_q <= S_DLD;
					end else begin
						lane_q  <= lane_q + 2'd1;
						state_q <= S_AM;
					end
				end
				S_CL: begin
					cnt_q   <= '0;
					state_q <= S_CD;
				end
				S_CD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == stps_pkg::COL_LAST) begin
						state_q <= S_CS;
					end
				end
				S_CS: begin
					if (lane_q == 2'd2) begin
						state_q <= S_FIN;
					end else begin
						lane_q  <= lane_q + 2'd1;
						state_q <= S_CL;
					end
				end
				S_MISS: state_q <= S_FIN;
				S_FIN: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.lane = lane_q;
		cmd.hit  = hit_q;
		cmd.cap  = cap_q;
		cmd.op   = stps_pkg::OP_NOP;
		unique case (state_q)
			S_IDLE:   cmd.op = start ? stps_pkg::OP_LOAD : stps_pkg::OP_NOP;
			S_GMUL:   cmd.op = stps_pkg::OP_MUL_GND;
			S_GCMP:   cmd.op = stps_pkg::OP_GND;
			S_NSHIFT: begin
				if (sts.mag_zero) begin
					cmd.op = stps_pkg::OP_ZERO_DIR;
				end else if (!sts.mag_norm) begin
					cmd.op = stps_pkg::OP_SHL;
				end
			end
			S_SQM:    cmd.op = stps_pkg::OP_MUL_SQ;
			S_SQA:    cmd.op = stps_pkg::OP_ACC;
			S_RTI:    cmd.op = stps_pkg::OP_RT_INIT;
			S_RT:     cmd.op = stps_pkg::OP_RT_STEP;
			S_DVL:    cmd.op = stps_pkg::OP_DIV_NORM;
			S_DV:     cmd.op = stps_pkg::OP_DIV_STEP;
			S_DSET:   cmd.op = stps_pkg::OP_DIR_SET;
			S_DLD:    cmd.op = stps_pkg::OP_DIST_LOAD;
			S_DSHR:   cmd.op = sts.mag_wide ? stps_pkg::OP_SHR : stps_pkg::OP_NOP;
			S_DFIN:   cmd.op = grows ? stps_pkg::OP_NOP : stps_pkg::OP_DIST_SET;
			S_AM:     cmd.op = stps_pkg::OP_MUL_ADV;
			S_AA:     cmd.op = stps_pkg::OP_ADV;
			S_CL:     cmd.op = stps_pkg::OP_COL_LOAD;
			S_CD:     cmd.op = stps_pkg::OP_DIV_STEP;
			S_CS:     cmd.op = stps_pkg::OP_COL_SET;
			S_MISS:   cmd.op = stps_pkg::OP_MISS;
			S_FIN:    cmd.op = stps_pkg::OP_FINISH;
			default:  cmd.op = stps_pkg::OP_NOP;
		endcase
	end

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held longer than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobed while still busy");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= STEP_W'(MAX_STEPS)) else $error("step count past the cap");

endmodule

### rtl/core/stps_dpath.sv
// datapath: config registers, shared multiplier, bit-serial root and divider,
// ray position and distance registers, result registers; uses stps_pkg
module stps_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_addr,
	input  logic [31:0]        cfg_wdata,
	input  logic signed [31:0] ray_dir_x,
	input  logic signed [31:0] ray_dir_y,
	input  logic signed [31:0] ray_dir_z,
	input  logic [11:0]        pixel_x,
	input  logic [11:0]        pixel_y,
	input  stps_pkg::dp_cmd_t  cmd,
	output stps_pkg::dp_sts_t  sts,
	output logic [11:0]        out_x,
	output logic [11:0]        out_y,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic               sphere_hit,
	output logic               step_cap_reached
);

	localparam int MAG_W  = stps_pkg::MAG_W;
	localparam int POS_W  = stps_pkg::POS_W;
	localparam int DIST_W = stps_pkg::DIST_W;
	localparam int DIV_W  = stps_pkg::DIV_W;
	localparam int PROD_W = stps_pkg::PROD_W;
	localparam int ACC_W  = stps_pkg::ACC_W;
	localparam int DIR_W  = stps_pkg::DIR_W;
	localparam int F      = stps_pkg::FRAC_BITS;

	// configuration
	logic signed [31:0] eye_q [3];
	logic [30:0]        radius_q;
	logic [16:0]        thr_q;
	logic [30:0]        grange_q;

	// item context
	logic [11:0]              tag_x_q, tag_y_q;
	logic [2:0]               neg_q;
	logic                     ground_q;
	logic [MAG_W-1:0]         mag_q [3];
	logic [DIR_W-1:0]         dmag_q [3];
	logic signed [POS_W-1:0]  pos_q [3];
	logic signed [DIST_W-1:0] dist_q;
	logic [stps_pkg::K_W-1:0] k_q;
	logic [7:0]               col_q [3];

	// shared units
	logic [PROD_W-1:0] prod_q;
	logic [ACC_W-1:0]  acc_q;
	logic [63:0]       rv_q, rr_q, rb_q;
	logic [DIV_W-1:0]  rem_q, dsh_q;
	logic [DIR_W-1:0]  quo_q;
	logic              big_q;

	logic [30:0]              r_eff;
	logic [31:0]              twor;
	logic [31:0]              root;
	logic [DIST_W-1:0]        root_sh;
	logic signed [DIST_W-1:0] nd;
	logic [32:0]              mul_a;
	logic [31:0]              mul_b;
	logic [63:0]              rt_sum;
	logic [31:0]              abs_x, abs_y, abs_z;
	logic signed [POS_W:0]    num;
	logic signed [POS_W+8:0]  v255;
	logic                     num_pos;
	logic signed [POS_W:0]    rz_diff;
	logic [POS_W-1:0]         step_m;
	logic signed [PROD_W:0]   gnd_lhs;
	logic signed [PROD_W:0]   gnd_rhs;

	assign r_eff   = (radius_q == '0) ? 31'd1 : radius_q;
	assign twor    = {r_eff, 1'b0};
	assign root    = rr_q[31:0];
	assign root_sh = DIST_W'(root) << k_q;
	assign nd      = $signed(root_sh) - $signed(DIST_W'(r_eff));
	assign rt_sum  = rr_q + rb_q;
	assign step_m  = prod_q[POS_W+F-1:F];
	assign rz_diff = $signed((POS_W+1)'(r_eff)) - $signed({pos_q[2][POS_W-1], pos_q[2]});
	assign gnd_lhs = $signed({{(PROD_W-47){eye_q[2][31]}}, eye_q[2], {F{1'b0}}});
	assign gnd_rhs = $signed({1'b0, prod_q});

	assign abs_x = ray_dir_x[31] ? 32'd0 - ray_dir_x : ray_dir_x;
	assign abs_y = ray_dir_y[31] ? 32'd0 - ray_dir_y : ray_dir_y;
	assign abs_z = ray_dir_z[31] ? 32'd0 - ray_dir_z : ray_dir_z;

	always_comb begin
		sts.mag_zero = ((mag_q[0] | mag_q[1] | mag_q[2]) == '0);
		sts.mag_norm = ((mag_q[0][MAG_W-1:30] | mag_q[1][MAG_W-1:30]
			| mag_q[2][MAG_W-1:30]) != '0);
		sts.mag_wide = ((mag_q[0][MAG_W-1:31] | mag_q[1][MAG_W-1:31]
			| mag_q[2][MAG_W-1:31]) != '0);
		sts.nd_grows = (nd > dist_q);
		sts.nd_hit   = (nd <= $signed(DIST_W'(thr_q)));
	end

	// operand select for the one multiplier
	always_comb begin
		case (cmd.op)
			stps_pkg::OP_MUL_SQ: begin
				mul_a = mag_q[cmd.lane][32:0];
				mul_b = mag_q[cmd.lane][31:0];
			end
			stps_pkg::OP_MUL_ADV: begin
				mul_a = dist_q[32:0];
				mul_b = 32'(dmag_q[cmd.lane]);
			end
			default: begin
				mul_a = {2'b00, grange_q};
				mul_b = mag_q[2][31:0];
			end
		endcase
	end

	// hit colour numerator, 255 * num as (num << 8) - num
	always_comb begin
		case (cmd.lane)
			2'd0:    num = $signed({pos_q[0][POS_W-1], pos_q[0]}) + $signed((POS_W+1)'(r_eff));
			2'd1:    num = $signed({pos_q[1][POS_W-1], pos_q[1]}) + $signed((POS_W+1)'(r_eff));
			default: num = $signed({pos_q[2][POS_W-1], pos_q[2]});
		endcase
		num_pos = !num[POS_W] && (num != '0);
		v255    = $signed({num, 8'd0}) - $signed({{8{num[POS_W]}}, num});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_q[0] <= stps_pkg::EYE_RST;
			eye_q[1] <= stps_pkg::EYE_RST;
			eye_q[2] <= stps_pkg::EYE_RST;
			radius_q <= stps_pkg::RADIUS_RST;
			thr_q    <= stps_pkg::THR_RST;
			grange_q <= stps_pkg::GROUND_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				stps_pkg::CFG_EYE_X:     eye_q[0] <= cfg_wdata;
				stps_pkg::CFG_EYE_Y:     eye_q[1] <= cfg_wdata;
				stps_pkg::CFG_EYE_Z:     eye_q[2] <= cfg_wdata;
				stps_pkg::CFG_RADIUS:    radius_q <= cfg_wdata[30:0];
				stps_pkg::CFG_THRESHOLD: thr_q    <= cfg_wdata[16:0];
				stps_pkg::CFG_GROUND:    grange_q <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		case (cmd.op)
			stps_pkg::OP_LOAD: begin
				tag_x_q  <= pixel_x;
				tag_y_q  <= pixel_y;
				neg_q    <= {ray_dir_z[31], ray_dir_y[31], ray_dir_x[31]};
				mag_q[0] <= MAG_W'(abs_x);
				mag_q[1] <= MAG_W'(abs_y);
				mag_q[2] <= MAG_W'(abs_z);
				pos_q[0] <= POS_W'(eye_q[0]);
				pos_q[1] <= POS_W'(eye_q[1]);
				pos_q[2] <= POS_W'(eye_q[2]);
				acc_q    <= '0;
			end
			stps_pkg::OP_SHL: begin
				for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
			end
			stps_pkg::OP_ZERO_DIR: begin
				for (int i = 0; i < 3; i++) dmag_q[i] <= '0;
			end
			stps_pkg::OP_GND: begin
				ground_q <= neg_q[2] && (gnd_lhs < gnd_rhs);
			end
			stps_pkg::OP_ACC: acc_q <= acc_q + prod_q[ACC_W-1:0];
			stps_pkg::OP_RT_INIT: begin
				rv_q <= acc_q;
				rr_q <= '0;
				rb_q <= 64'd1 << 62;
			end
			stps_pkg::OP_RT_STEP: begin
				if (rv_q >= rt_sum) begin
					rv_q <= rv_q - rt_sum;
					rr_q <= (rr_q >> 1) + rb_q;
				end else begin
					rr_q <= rr_q >> 1;
				end
				rb_q <= rb_q >> 2;
			end
			stps_pkg::OP_DIV_NORM: begin
				rem_q <= DIV_W'({mag_q[cmd.lane][31:0], {F{1'b0}}});
				dsh_q <= DIV_W'({root, {F{1'b0}}});
				quo_q <= '0;
			end
			stps_pkg::OP_DIV_STEP: begin
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
					quo_q <= {quo_q[DIR_W-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[DIR_W-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
			end
			stps_pkg::OP_DIR_SET: dmag_q[cmd.lane] <= quo_q;
			stps_pkg::OP_DIST_LOAD: begin
				mag_q[0] <= pos_q[0][POS_W-1] ? MAG_W'(-pos_q[0]) : MAG_W'(pos_q[0]);
				mag_q[1] <= pos_q[1][POS_W-1] ? MAG_W'(-pos_q[1]) : MAG_W'(pos_q[1]);
				mag_q[2] <= rz_diff[POS_W] ? MAG_W'(-rz_diff) : MAG_W'(rz_diff);
				k_q      <= '0;
				acc_q    <= '0;
			end
			stps_pkg::OP_SHR: begin
				for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
				k_q <= k_q + 1'b1;
			end
			stps_pkg::OP_DIST_SET: dist_q <= nd;
			stps_pkg::OP_ADV: begin
				if (neg_q[cmd.lane]) begin
					pos_q[cmd.lane] <= pos_q[cmd.lane] - $signed(step_m);
				end else begin
					pos_q[cmd.lane] <= pos_q[cmd.lane] + $signed(step_m);
				end
			end
			stps_pkg::OP_COL_LOAD: begin
				rem_q <= num_pos ? DIV_W'(v255) : '0;
				big_q <= num_pos && (v255 >= $signed((POS_W+9)'({twor, 8'd0})));
				dsh_q <= DIV_W'({twor, 7'd0});
				quo_q <= '0;
			end
			stps_pkg::OP_COL_SET: col_q[cmd.lane] <= big_q ? stps_pkg::COL_FULL : quo_q[7:0];
			stps_pkg::OP_MISS: begin
				col_q[0] <= ground_q ? stps_pkg::COL_FULL : stps_pkg::COL_LOW;
				col_q[1] <= stps_pkg::COL_MID;
				col_q[2] <= ground_q ? stps_pkg::COL_LOW : stps_pkg::COL_FULL;
			end
			stps_pkg::OP_FINISH: begin
				out_x            <= tag_x_q;
				out_y            <= tag_y_q;
				red              <= col_q[0];
				green            <= col_q[1];
				blue             <= col_q[2];
				sphere_hit       <= cmd.hit;
				step_cap_reached <= cmd.cap;
			end
			default: ;
		endcase
	end

	// advancing distance is non-negative and fits the multiplier's 33-bit operand
	a_adv_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == stps_pkg::OP_MUL_ADV |-> !dist_q[DIST_W-1] && dist_q[DIST_W-2:33] == '0)
		else $error("advance distance out of multiplier range");

	a_unit_dir: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == stps_pkg::OP_DIR_SET |-> quo_q <= DIR_W'(1 << F))
		else $error("unit direction component above one");

	a_hit_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == stps_pkg::OP_FINISH |-> !(cmd.hit && cmd.cap))
		else $error("hit and step cap both flagged");

endmodule

### rtl/core/sphere_trace_pixel_shader.sv
// top level of the sphere trace pixel shader
// joins stps_ctrl and stps_dpath; uses stps_pkg for command and status
//
// usage: with busy low, raise start for one cycle with ray_dir_x/y/z and
// pixel_x/y on the ports; the item is taken at that edge and busy rises.
// when the pixel is shaded, done is high for exactly one cycle with out_x,
// out_y, red, green, blue, sphere_hit and step_cap_reached valid; the
// receiver has to take it then. busy is low again in the done cycle, so
// the next item may start there. one item is processed at a time.
// configuration: cfg_we, cfg_addr, cfg_wdata write a register; the user writes
// only while busy is low and no result is pending; the block does not enforce it.
// sequence: set-up and normalization, then one distance evaluation per march
// step plus the first, an advance per step, and a colour division on a hit;
// the bit-serial square root in each distance evaluation takes most of the time.
// reset: arst_n clears the controller to idle and loads the default
// configuration; result ports are undefined until the first done.
module sphere_trace_pixel_shader #(
	parameter int MAX_STEPS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_addr,
	input  logic [31:0]        cfg_wdata,
	input  logic signed [31:0] ray_dir_x,
	input  logic signed [31:0] ray_dir_y,
	input  logic signed [31:0] ray_dir_z,
	input  logic [11:0]        pixel_x,
	input  logic [11:0]        pixel_y,
	output logic [11:0]        out_x,
	output logic [11:0]        out_y,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic               sphere_hit,
	output logic               step_cap_reached
);

	stps_pkg::dp_cmd_t cmd;
	stps_pkg::dp_sts_t sts;

	stps_ctrl #(
		.MAX_STEPS(MAX_STEPS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.cmd    (cmd)
	);

	stps_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_addr         (cfg_addr),
		.cfg_wdata        (cfg_wdata),
		.ray_dir_x        (ray_dir_x),
		.ray_dir_y        (ray_dir_y),
		.ray_dir_z        (ray_dir_z),
		.pixel_x          (pixel_x),
		.pixel_y          (pixel_y),
		.cmd              (cmd),
		.sts              (sts),
		.out_x            (out_x),
		.out_y            (out_y),
		.red              (red),
		.green            (green),
		.blue             (blue),
		.sphere_hit       (sphere_hit),
		.step_cap_reached (step_cap_reached)
	);

endmodule
